// ===== hdl/i2c_bitbang_master_assert.svh =====
// Assertion macros shared by the bit engine RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef I2C_BITBANG_MASTER_ASSERT_SVH
`define I2C_BITBANG_MASTER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define I2CBB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define I2CBB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/i2cbb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package i2cbb_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int TICK_W        = 10;
  localparam logic [TICK_W-1:0] PHASE_TICKS_RESET = 10'd10;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_START,
    CMD_STOP,
    CMD_SEND_BYTE,
    CMD_READ_ACK,
    CMD_READ_BYTE,
    CMD_SEND_ACK,
    CMD_SEND_NACK
  } cmd_t;

  typedef struct packed {
    logic scl;
    logic sda;
  } pins_t;

  // Result of one tick; scl lands in bit 0 when packed onto the bus.
  typedef struct packed {
    logic       rejected;
    logic       ack_seen;
    logic [7:0] rx_byte;
    logic       done;
    logic       busy;
    logic       sda_out;
    logic       scl;
  } res_t;

  // Pin levels on entry to a phase; unchanged pins keep their current level.
  function automatic pins_t phase_levels(cmd_t cmd, logic [1:0] ph, logic [2:0] bit_idx,
                                         logic [7:0] tx, pins_t cur);
    pins_t p;
    logic [7:0] sh;
    p  = cur;
    sh = tx << bit_idx;
    case (cmd)
      CMD_START: begin
        if (ph == 2'd0) begin
          p.sda = 1'b1;
          p.scl = 1'b1;
        end else if (ph == 2'd1) begin
          p.sda = 1'b0;
        end else begin
          p.scl = 1'b0;
        end
      end
      CMD_STOP: begin
        if (ph == 2'd0) begin
          p.scl = 1'b0;
          p.sda = 1'b0;
        end else if (ph == 2'd1) begin
          p.scl = 1'b1;
        end else begin
          p.sda = 1'b1;
        end
      end
      CMD_SEND_BYTE: begin
        if (ph == 2'd0) begin
          p.sda = sh[7];
        end else if (ph == 2'd1) begin
          p.scl = 1'b1;
        end else begin
          p.scl = 1'b0;
        end
      end
      CMD_READ_ACK: begin
        if (ph == 2'd0) begin
          p.sda = 1'b1;
        end else if (ph == 2'd1) begin
          p.scl = 1'b1;
        end else begin
          p.scl = 1'b0;
        end
      end
      CMD_READ_BYTE: begin
        if (ph == 2'd0) begin
          p.scl = 1'b1;
          p.sda = 1'b1;
        end else begin
          p.scl = 1'b0;
        end
      end
      CMD_SEND_ACK, CMD_SEND_NACK: begin
        if (ph == 2'd0) begin
          p.scl = 1'b0;
          p.sda = (cmd == CMD_SEND_NACK);
        end else if (ph == 2'd1) begin
          p.scl = 1'b1;
        end else begin
          p.scl = 1'b0;
        end
      end
      default: begin
        p = cur;
      end
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/i2cbb_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_bitbang_master_assert.svh"
module i2cbb_engine (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               cfg_we,
  input  wire  [i2cbb_pkg::TICK_W-1:0]      cfg_wdata,
  input  wire                               step_en,
  input  wire  i2cbb_pkg::cmd_t             func,
  input  wire  [7:0]                        tx_byte,
  input  wire                               sda_in,
  output i2cbb_pkg::res_t                   res
);
  import i2cbb_pkg::*;

  logic [TICK_W-1:0] phase_ticks_r;
  cmd_t              cmd_r, cmd_nxt;
  logic [1:0]        ph_r, ph_nxt;
  logic [2:0]        bit_r, bit_nxt;
  logic [TICK_W-1:0] tmr_r, tmr_nxt;
  logic [7:0]        tx_r, tx_nxt;
  logic [7:0]        rx_r, rx_nxt;
  logic              ack_r, ack_nxt;
  pins_t             pins_r, pins_nxt;

  logic [TICK_W-1:0] ticks;
  logic [1:0]        ph_last;
  logic [3:0]        bits_last;
  logic [3:0]        bit_inc;
  logic              busy, done, rej;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= PHASE_TICKS_RESET;
    end else if (cfg_we) begin
      phase_ticks_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r  <= CMD_NONE;
      ph_r   <= 2'd0;
      bit_r  <= 3'd0;
      tmr_r  <= '0;
      tx_r   <= 8'd0;
      rx_r   <= 8'd0;
      ack_r  <= 1'b0;
      pins_r <= '{scl: 1'b1, sda: 1'b1};
    end else if (step_en) begin
      cmd_r  <= cmd_nxt;
      ph_r   <= ph_nxt;
      bit_r  <= bit_nxt;
      tmr_r  <= tmr_nxt;
      tx_r   <= tx_nxt;
      rx_r   <= rx_nxt;
      ack_r  <= ack_nxt;
      pins_r <= pins_nxt;
    end
  end

  always_comb begin
    cmd_nxt   = cmd_r;
    ph_nxt    = ph_r;
    bit_nxt   = bit_r;
    tmr_nxt   = tmr_r;
    tx_nxt    = tx_r;
    rx_nxt    = rx_r;
    ack_nxt   = ack_r;
    pins_nxt  = pins_r;
    busy      = 1'b0;
    done      = 1'b0;
    rej       = 1'b0;
    bit_inc   = 4'd0;
    ticks     = (phase_ticks_r == '0) ? TICK_W'(1) : phase_ticks_r;

    // Accept a new command only when idle; otherwise drop and flag it.
    if (func != CMD_NONE) begin
      if (cmd_r != CMD_NONE) begin
        rej = 1'b1;
      end else begin
        cmd_nxt = func;
        ph_nxt  = 2'd0;
        bit_nxt = 3'd0;
        tmr_nxt = '0;
        if (func == CMD_SEND_BYTE) begin
          tx_nxt = tx_byte;
        end
        pins_nxt = phase_levels(func, 2'd0, 3'd0, tx_nxt, pins_r);
      end
    end

    ph_last   = (cmd_nxt == CMD_READ_BYTE) ? 2'd2 : 2'd3;
    bits_last = (cmd_nxt == CMD_SEND_BYTE || cmd_nxt == CMD_READ_BYTE) ?
                4'(BITS_PER_BYTE) : 4'd1;

    if (cmd_nxt != CMD_NONE) begin
      busy    = 1'b1;
      tmr_nxt = tmr_nxt + TICK_W'(1);
      if (tmr_nxt >= ticks) begin
        // Sample SDA on the last tick of the clock-high phase.
        if (cmd_nxt == CMD_READ_ACK && ph_nxt == 2'd1) begin
          ack_nxt = ~sda_in;
        end
        if (cmd_nxt == CMD_READ_BYTE && ph_nxt == 2'd0) begin
          rx_nxt = {rx_nxt[6:0], sda_in};
        end
        tmr_nxt = '0;
        ph_nxt  = ph_nxt + 2'd1;
        if (ph_nxt >= ph_last) begin
          ph_nxt  = 2'd0;
          bit_inc = {1'b0, bit_nxt} + 4'd1;
          bit_nxt = bit_inc[2:0];
          if (bit_inc >= bits_last) begin
            bit_nxt = 3'd0;
            cmd_nxt = CMD_NONE;
            done    = 1'b1;
          end
        end
        if (cmd_nxt != CMD_NONE) begin
          pins_nxt = phase_levels(cmd_nxt, ph_nxt, bit_nxt, tx_nxt, pins_nxt);
        end
      end
    end
  end

  assign res = '{rejected: rej, ack_seen: ack_nxt, rx_byte: rx_nxt, done: done,
                 busy: busy, sda_out: pins_nxt.sda, scl: pins_nxt.scl};

  `I2CBB_ASSERT_NOW(a_idle_clean, cmd_r == CMD_NONE, ph_r == 2'd0 && bit_r == 3'd0 && tmr_r == '0, "idle engine holds stale sequencing state")
  `I2CBB_ASSERT_NOW(a_phase_range, 1'b1, ph_r != 2'd3, "phase index out of range")
  `I2CBB_ASSERT_NEXT(a_done_idle, step_en && done, cmd_r == CMD_NONE, "engine still active after finishing a command")
  `I2CBB_ASSERT_NOW(a_reject_busy, step_en && rej, cmd_r != CMD_NONE, "command dropped while idle")

endmodule
`default_nettype wire

// ===== hdl/i2cbb_skid.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_bitbang_master_assert.svh"
module i2cbb_skid (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire i2cbb_pkg::res_t in_data,
  output logic             out_valid,
  input  wire              out_ready,
  output i2cbb_pkg::res_t  out_data
);
  import i2cbb_pkg::*;

  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t out_data_r, out_data_nxt;
  res_t skid_data_r, skid_data_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign in_ready = ~skid_valid_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_ready || !out_valid_r) begin
      if (skid_valid_r) begin
        // Drain the skid entry first to keep transaction order.
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = in_valid;
        out_data_nxt  = in_data;
      end
    end else if (in_valid && !skid_valid_r) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = in_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `I2CBB_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r, "skid entry held with empty output register")
  `I2CBB_ASSERT_NEXT(a_stall_fills_skid, out_valid_r && !out_ready && in_valid && in_ready, skid_valid_r, "stalled transaction lost")

endmodule
`default_nettype wire

// ===== hdl/i2c_bitbang_master.sv =====
// I2C master bit engine. Each input transaction is one microsecond tick and may carry a
// command in in_tuser (start, stop, send byte, read ACK, read byte, send ACK, send NACK);
// every tick yields exactly one result transaction with the SCL/SDA drive levels (1 means
// released), busy/done flags, the receive shift register, the last ACK seen and a flag
// for a command dropped because another was still running. Each bus phase lasts
// cfg_wdata ticks (0 acts as 1, reset value 10); write it only while no tick transaction
// is in flight. A write while a command runs applies to the running phase, which ends as
// soon as its elapsed ticks reach the new length. The block takes one tick per clock
// cycle while it is ready to accept; the tick's update is short logic between the engine
// state registers and a two-entry output stage that registers the result, so one more
// tick is accepted while the output side is stalled.
`timescale 1ns / 1ps
`default_nettype none
module i2c_bitbang_master (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire  [9:0]  cfg_wdata,     // phase_ticks
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [15:0] in_tdata,      // tx_byte[7:0], sda_in[8], zero [15:9]
  input  wire  [2:0]  in_tuser,      // func[2:0]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata      // scl[0], sda_out[1], busy_res[2], done_res[3],
                                     // rx_byte[11:4], ack_seen[12], rejected[13], zero
);
  import i2cbb_pkg::*;

  logic step_en;
  res_t step_res;
  res_t out_res;

  assign step_en = in_tvalid & in_tready;

  i2cbb_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step_en   (step_en),
    .func      (cmd_t'(in_tuser)),
    .tx_byte   (in_tdata[7:0]),
    .sda_in    (in_tdata[8]),
    .res       (step_res)
  );

  i2cbb_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (step_en),
    .in_ready  (in_tready),
    .in_data   (step_res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tdata = {2'b00, out_res};

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import i2cbb_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int N_LENS      = 10;

  typedef struct {
    cmd_t       f;
    logic [7:0] tx;
    logic       sda;
    bit         typed;
    res_t       want;
  } tick_row_t;

  localparam res_t IDLE_RES = '{rejected: 1'b0, ack_seen: 1'b0, rx_byte: 8'h00, done: 1'b0,
                                busy: 1'b0, sda_out: 1'b1, scl: 1'b1};
  localparam res_t DROP_RES = '{rejected: 1'b1, ack_seen: 1'b0, rx_byte: 8'h00, done: 1'b0,
                                busy: 1'b1, sda_out: 1'b0, scl: 1'b0};
  localparam res_t START_END_RES = '{rejected: 1'b0, ack_seen: 1'b0, rx_byte: 8'h00,
                                     done: 1'b1, busy: 1'b1, sda_out: 1'b0, scl: 1'b0};

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [9:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;

  // Bit engine model state
  logic [9:0]  len_q;
  logic        scl_q;
  logic        sda_q;
  cmd_t        cmd_q;
  int unsigned ph_q;
  int unsigned bit_q;
  logic [9:0]  tmr_q;
  logic [7:0]  txsh_q;
  logic [7:0]  rxsh_q;
  logic        ack_q;

  res_t        pending_ticks[$];
  int          errors;
  int          ticks_sent;
  int          cmds_done;
  int          cmds_dropped;
  int          results_seen;
  int          hold_off_req;
  bit          quiet;
  logic [9:0]  phase_lens [N_LENS];
  tick_row_t   plan [24];

  i2c_bitbang_master dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

  // Pin levels on entry to the current phase; pins not named keep their level.
  function void load_phase();
    case (cmd_q)
      CMD_START: begin
        case (ph_q)
          0: begin
            sda_q = 1'b1;
            scl_q = 1'b1;
          end
          1: sda_q = 1'b0;
          default: scl_q = 1'b0;
        endcase
      end
      CMD_STOP: begin
        case (ph_q)
          0: begin
            scl_q = 1'b0;
            sda_q = 1'b0;
          end
          1: scl_q = 1'b1;
          default: sda_q = 1'b1;
        endcase
      end
      CMD_SEND_BYTE: begin
        case (ph_q)
          0: sda_q = txsh_q[7 - bit_q];
          1: scl_q = 1'b1;
          default: scl_q = 1'b0;
        endcase
      end
      CMD_READ_ACK: begin
        case (ph_q)
          0: sda_q = 1'b1;
          1: scl_q = 1'b1;
          default: scl_q = 1'b0;
        endcase
      end
      CMD_READ_BYTE: begin
        if (ph_q == 0) begin
          scl_q = 1'b1;
          sda_q = 1'b1;
        end else begin
          scl_q = 1'b0;
        end
      end
      CMD_SEND_ACK, CMD_SEND_NACK: begin
        case (ph_q)
          0: begin
            scl_q = 1'b0;
            sda_q = (cmd_q == CMD_SEND_NACK);
          end
          1: scl_q = 1'b1;
          default: scl_q = 1'b0;
        endcase
      end
      default: ;
    endcase
  endfunction

  // Advance the engine by one tick and return the pin and status levels after it.
  function res_t advance_tick(cmd_t f, logic [7:0] tx, logic sda);
    res_t        r;
    logic [9:0]  span;
    int unsigned per_bit;
    int unsigned nbits;
    r    = '0;
    span = (len_q == 10'd0) ? 10'd1 : len_q;
    if (f != CMD_NONE) begin
      if (cmd_q != CMD_NONE) begin
        r.rejected = 1'b1;
      end else begin
        cmd_q = f;
        ph_q  = 0;
        bit_q = 0;
        tmr_q = '0;
        if (f == CMD_SEND_BYTE)
          txsh_q = tx;
        load_phase();
      end
    end
    if (cmd_q != CMD_NONE) begin
      r.busy = 1'b1;
      tmr_q  = tmr_q + 10'd1;
      if (tmr_q >= span) begin
        if (cmd_q == CMD_READ_ACK && ph_q == 1)
          ack_q = ~sda;
        if (cmd_q == CMD_READ_BYTE && ph_q == 0)
          rxsh_q = {rxsh_q[6:0], sda};
        tmr_q   = '0;
        ph_q    = ph_q + 1;
        per_bit = (cmd_q == CMD_READ_BYTE) ? 2 : 3;
        nbits   = (cmd_q == CMD_SEND_BYTE || cmd_q == CMD_READ_BYTE) ? BITS_PER_BYTE : 1;
        if (ph_q >= per_bit) begin
          ph_q  = 0;
          bit_q = bit_q + 1;
          if (bit_q >= nbits) begin
            bit_q  = 0;
            cmd_q  = CMD_NONE;
            r.done = 1'b1;
          end
        end
        if (cmd_q != CMD_NONE)
          load_phase();
      end
    end
    r.scl      = scl_q;
    r.sda_out  = sda_q;
    r.rx_byte  = rxsh_q;
    r.ack_seen = ack_q;
    return r;
  endfunction

  function int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endtask

  // Offer one tick, hold until the transaction completes, then optionally idle.
  task automatic feed_tick(input cmd_t f, input logic [7:0] tx, input logic sda,
                           input bit typed, input res_t want, input int gap);
    res_t r;
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= {7'b0, sda, tx};
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    r = advance_tick(f, tx, sda);
    if (r.done)
      cmds_done++;
    if (r.rejected)
      cmds_dropped++;
    pending_ticks.push_back(typed ? want : r);
    ticks_sent++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    if (in_tvalid)
      in_tvalid <= 1'b0;
    while (pending_ticks.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_phase_len(input logic [9:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    len_q      = v;
  endtask

  // Result side: random back-pressure, one long hold-off on request.
  initial begin
    res_t got;
    res_t want;
    int   stall_left;
    stall_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got = res_t'(out_tdata[13:0]);
        results_seen++;
        if (pending_ticks.size() == 0) begin
          $error("result transaction with no tick pending");
          errors++;
        end else begin
          want = pending_ticks.pop_front();
          check_field("scl", want.scl, got.scl);
          check_field("sda_out", want.sda_out, got.sda_out);
          check_field("busy_res", want.busy, got.busy);
          check_field("done_res", want.done, got.done);
          check_field("rx_byte", want.rx_byte, got.rx_byte);
          check_field("ack_seen", want.ack_seen, got.ack_seen);
          check_field("rejected", want.rejected, got.rejected);
        end
      end
      if (hold_off_req != 0) begin
        stall_left   = HOLD_CYCLES;
        hold_off_req = 0;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0)
          stall_left = idle_span();
      end
    end
  end

  initial begin
    cmd_t       f;
    logic [7:0] tx;
    int         n;
    int         r;
    errors       = 0;
    ticks_sent   = 0;
    cmds_done    = 0;
    cmds_dropped = 0;
    results_seen = 0;
    hold_off_req = 0;
    quiet        = 1'b0;
    len_q  = PHASE_TICKS_RESET;
    scl_q  = 1'b1;
    sda_q  = 1'b1;
    cmd_q  = CMD_NONE;
    ph_q   = 0;
    bit_q  = 0;
    tmr_q  = '0;
    txsh_q = '0;
    rxsh_q = '0;
    ack_q  = 1'b0;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tuser  <= CMD_NONE;
    in_tdata  <= '0;

    phase_lens = '{10'd1, 10'd0, 10'd2, 10'd3, 10'd1023, 10'd1, 10'd5, 10'd2, 10'd4, 10'd1};
    phase_lens[8] = 10'($urandom_range(1, 6));

    // Directed ticks with one-tick phases.
    plan[0]  = '{CMD_NONE,      8'h00, 1'b0, 1'b1, IDLE_RES};
    plan[1]  = '{CMD_START,     8'h00, 1'b1, 1'b0, '0};
    plan[2]  = '{CMD_SEND_BYTE, 8'hFF, 1'b0, 1'b1, DROP_RES};
    plan[3]  = '{CMD_NONE,      8'h00, 1'b0, 1'b1, START_END_RES};
    plan[4]  = '{CMD_READ_ACK,  8'h00, 1'b1, 1'b0, '0};
    plan[5]  = '{CMD_NONE,      8'h00, 1'b0, 1'b0, '0};
    plan[6]  = '{CMD_NONE,      8'h00, 1'b1, 1'b0, '0};
    plan[7]  = '{CMD_READ_ACK,  8'h00, 1'b1, 1'b0, '0};
    plan[8]  = '{CMD_NONE,      8'h00, 1'b1, 1'b0, '0};
    plan[9]  = '{CMD_NONE,      8'h00, 1'b0, 1'b0, '0};
    plan[10] = '{CMD_SEND_ACK,  8'h00, 1'b0, 1'b0, '0};
    plan[11] = '{CMD_NONE,      8'h00, 1'b0, 1'b0, '0};
    plan[12] = '{CMD_NONE,      8'h00, 1'b1, 1'b0, '0};
    plan[13] = '{CMD_SEND_NACK, 8'h00, 1'b0, 1'b0, '0};
    plan[14] = '{CMD_NONE,      8'h00, 1'b0, 1'b0, '0};
    plan[15] = '{CMD_NONE,      8'h00, 1'b0, 1'b0, '0};
    plan[16] = '{CMD_STOP,      8'h00, 1'b0, 1'b0, '0};
    plan[17] = '{CMD_STOP,      8'hFF, 1'b1, 1'b0, '0};
    // command on the finishing tick of stop is dropped too
    plan[18] = '{CMD_SEND_NACK, 8'h00, 1'b0, 1'b0, '0};
    plan[19] = '{CMD_READ_BYTE, 8'hFF, 1'b1, 1'b0, '0};
    plan[20] = '{CMD_NONE,      8'h00, 1'b1, 1'b0, '0};
    plan[21] = '{CMD_READ_ACK,  8'h00, 1'b0, 1'b0, '0};
    plan[22] = '{CMD_NONE,      8'hFF, 1'b0, 1'b0, '0};
    plan[23] = '{CMD_NONE,      8'h00, 1'b1, 1'b0, '0};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_phase_len(10'd1);
    foreach (plan[i])
      feed_tick(plan[i].f, plan[i].tx, plan[i].sda, plan[i].typed, plan[i].want,
                ($urandom_range(0, 3) == 0) ? idle_span() : 0);

    // Each phase length is written once the pipe is empty; a command may still be
    // running in the engine, which exercises a length change mid-phase.
    for (int p = 0; p < N_LENS; p++) begin
      wait_drained();
      set_phase_len(phase_lens[p]);
      quiet = (p == 3 || p == 7);
      n = (phase_lens[p] == 10'd1023) ? 80 : 200;
      for (int k = 0; k < n; k++) begin
        if (p == 2 && k == 40)
          hold_off_req = 1;
        if (p == 5 && k == 100)
          wait_drained();
        if (cmd_q == CMD_NONE)
          f = ($urandom_range(0, 1) != 0) ? cmd_t'($urandom_range(1, 7)) : CMD_NONE;
        else
          f = ($urandom_range(0, 29) == 0) ? cmd_t'($urandom_range(1, 7)) : CMD_NONE;
        r = $urandom_range(0, 9);
        tx = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(0, 255));
        feed_tick(f, tx, 1'($urandom_range(0, 1)), 1'b0, '0,
                  (!quiet && $urandom_range(0, 3) == 0) ? idle_span() : 0);
      end
    end

    wait_drained();
    repeat (4) @(posedge clk);
    $display("Ticks sent: %0d over %0d phase lengths (0, 1 and 1023 among them)",
             ticks_sent, N_LENS + 1);
    $display("Commands completed: %0d, dropped while busy: %0d, results checked: %0d",
             cmds_done, cmds_dropped, results_seen);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/i2cbb_pkg.sv
hdl/i2cbb_engine.sv
hdl/i2cbb_skid.sv
hdl/i2c_bitbang_master.sv
verif/testbench.sv
